### sv/mtfp_pkg.sv
// ----------------------------------------------------------------------------
// mtfp_pkg
// Types, constants and helper functions for the telemetry frame parser.
// ----------------------------------------------------------------------------
package mtfp_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  DATA_BYTE_COUNT   = 8'd32;
    localparam logic [3:0]  BCD_DIGIT_MAX     = 4'd9;

    // Byte positions within the frame.
    localparam logic [5:0] POS_SLAVE      = 6'd0;
    localparam logic [5:0] POS_FUNCTION   = 6'd1;
    localparam logic [5:0] POS_COUNT      = 6'd2;
    localparam logic [5:0] POS_DATA_FIRST = 6'd3;
    localparam logic [5:0] POS_DATA_LAST  = 6'd34;
    localparam logic [5:0] POS_BCD_FIRST  = 6'd15;
    localparam logic [5:0] POS_BCD_SPLIT  = 6'd21;
    localparam logic [5:0] POS_BCD_LAST   = 6'd26;
    localparam logic [5:0] POS_MIN_LAST   = 6'd36;
    localparam logic [5:0] POS_MAX        = 6'd63;

    // Data word indexes: words up to this one map straight to a slot,
    // words from the upper group are moved down past the BCD words.
    localparam logic [4:0] WORD_DIRECT_LAST = 5'd5;
    localparam logic [4:0] WORD_UPPER_FIRST = 5'd12;
    localparam logic [4:0] WORD_UPPER_SHIFT = 5'd6;

    localparam int WORD_SLOTS = 10;
    localparam int SLOT_W     = $clog2(WORD_SLOTS);
    localparam int TOTAL_W    = 40;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_FUNC  = 3'd2,
        ST_CRC_ERR   = 3'd3,
        ST_BAD_BCD   = 3'd4
    } t_parse_status;

    typedef struct packed {
        t_parse_status      parse_status;
        logic [7:0]         node_addr;
        logic [6:0]         status_bits;
        logic [15:0]        price_per_unit;
        logic [31:0]        delivery_quantity;
        logic [31:0]        delivery_amount;
        logic [TOTAL_W-1:0] quantity_total;
        logic [TOTAL_W-1:0] amount_total;
        logic [15:0]        line_pressure;
        logic [15:0]        flow_value;
        logic [15:0]        fault_flags;
        logic signed [15:0] ambient_temp;
    } t_result;

    // CRC-16/Modbus over one byte, reflected form.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Appends two BCD digits to a binary accumulator: acc * 100 + hi * 10 + lo,
    // wrapped to the accumulator width. The multiply is shifts and adds.
    function automatic logic [TOTAL_W-1:0] bcd_append(input logic [TOTAL_W-1:0] acc,
                                                       input logic [7:0] b);
        logic [7:0] digits;
        digits = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
        return {acc[TOTAL_W-7:0], 6'd0} + {acc[TOTAL_W-6:0], 5'd0}
             + {acc[TOTAL_W-3:0], 2'd0} + {{(TOTAL_W-8){1'b0}}, digits};
    endfunction

endpackage

### sv/modbus_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// modbus_telemetry_frame_parser
// Parses a read-holding-registers response byte by byte and reports one
// decoded telemetry result per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   i_data_byte, i_last_byte
//  result    out        o_valid / i_stall   o_parse_status ... o_ambient_temp
//
//  One byte is taken every cycle unless the input stalls; the CRC, capture
//  and BCD conversion all finish in the cycle the byte is transferred. The
//  result of a last byte is registered into the output slot, or into the
//  skid register behind it while the output is held by a stall. The skid
//  holds one more result, so the input stalls only when both are full.
//  Reset is synchronous, active low, and clears the frame state and both
//  output slots.
// ----------------------------------------------------------------------------
module modbus_telemetry_frame_parser
    import mtfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_parse_status,
    output logic [7:0]         o_node_addr,
    output logic [6:0]         o_status_bits,
    output logic [15:0]        o_price_per_unit,
    output logic [31:0]        o_delivery_quantity,
    output logic [31:0]        o_delivery_amount,
    output logic [39:0]        o_quantity_total,
    output logic [39:0]        o_amount_total,
    output logic [15:0]        o_line_pressure,
    output logic [15:0]        o_flow_value,
    output logic [15:0]        o_fault_flags,
    output logic signed [15:0] o_ambient_temp
);

    logic [5:0]         r_pos,      n_pos;
    logic [15:0]        r_crc,      n_crc;
    logic [7:0]         r_slave,    n_slave;
    logic [7:0]         r_function, n_function;
    logic [7:0]         r_count,    n_count;
    logic               r_bcd_fault, n_bcd_fault;
    logic [7:0]         r_pending,  n_pending;
    logic [15:0]        r_words [WORD_SLOTS];
    logic [15:0]        n_words [WORD_SLOTS];
    logic [TOTAL_W-1:0] r_qty_acc,  n_qty_acc;
    logic [TOTAL_W-1:0] r_amt_acc,  n_amt_acc;

    t_result r_out, r_skid, result;
    logic    r_out_valid, r_skid_valid;

    logic          accept;
    logic          produce;
    logic [15:0]   crc_next;
    logic [5:0]    data_idx;
    logic [4:0]    word_idx;
    logic [SLOT_W-1:0] slot;
    logic          slot_hit;
    logic [TOTAL_W-1:0] acc_sel;
    t_parse_status status;

    assign accept   = i_valid && !o_stall;
    assign produce  = accept && i_last_byte;
    assign crc_next = crc16_byte(r_crc, i_data_byte);
    assign data_idx = r_pos - POS_DATA_FIRST;
    assign word_idx = data_idx[5:1];
    assign acc_sel  = (r_pos >= POS_BCD_SPLIT) ? r_amt_acc : r_qty_acc;

    always_comb begin
        slot_hit = 1'b0;
        slot     = '0;
        if (word_idx <= WORD_DIRECT_LAST) begin
            slot_hit = 1'b1;
            slot     = word_idx[SLOT_W-1:0];
        end else if (word_idx >= WORD_UPPER_FIRST) begin
            slot_hit = 1'b1;
            slot     = SLOT_W'(word_idx - WORD_UPPER_SHIFT);
        end
    end

    // Next frame state for the byte on the input.
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_slave     = r_slave;
        n_function  = r_function;
        n_count     = r_count;
        n_bcd_fault = r_bcd_fault;
        n_pending   = r_pending;
        n_words     = r_words;
        n_qty_acc   = r_qty_acc;
        n_amt_acc   = r_amt_acc;
        if (accept) begin
            if (i_last_byte) begin
                // The frame ends here; everything returns to its reset value.
                n_pos       = '0;
                n_crc       = CRC_INIT;
                n_slave     = '0;
                n_function  = '0;
                n_count     = '0;
                n_bcd_fault = 1'b0;
                n_pending   = '0;
                for (int i = 0; i < WORD_SLOTS; i++) begin
                    n_words[i] = '0;
                end
                n_qty_acc   = '0;
                n_amt_acc   = '0;
            end else begin
                n_crc = crc_next;
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 6'd1;
                end
                if (r_pos == POS_SLAVE) begin
                    n_slave = i_data_byte;
                end else if (r_pos == POS_FUNCTION) begin
                    n_function = i_data_byte;
                end else if (r_pos == POS_COUNT) begin
                    n_count = i_data_byte;
                end else if (r_pos >= POS_BCD_FIRST && r_pos <= POS_BCD_LAST) begin
                    if (i_data_byte[7:4] > BCD_DIGIT_MAX
                            || i_data_byte[3:0] > BCD_DIGIT_MAX) begin
                        n_bcd_fault = 1'b1;
                    end
                    if (r_pos >= POS_BCD_SPLIT) begin
                        n_amt_acc = bcd_append(acc_sel, i_data_byte);
                    end else begin
                        n_qty_acc = bcd_append(acc_sel, i_data_byte);
                    end
                end else if (r_pos >= POS_DATA_FIRST && r_pos <= POS_DATA_LAST) begin
                    if (!data_idx[0]) begin
                        n_pending = i_data_byte;
                    end else if (slot_hit) begin
                        n_words[slot] = {r_pending, i_data_byte};
                    end
                end
            end
        end
    end

    // Result for a frame ending with the byte on the input. A passing frame is
    // at least 37 bytes long, so all data words are already captured here.
    always_comb begin
        if (r_pos < POS_MIN_LAST) begin
            status = ST_SHORT;
        end else if (r_function != FUNC_READ_HOLDING) begin
            status = ST_BAD_FUNC;
        end else if (r_count != DATA_BYTE_COUNT) begin
            status = ST_SHORT;
        end else if (crc_next != 16'h0000) begin
            status = ST_CRC_ERR;
        end else if (r_bcd_fault) begin
            status = ST_BAD_BCD;
        end else begin
            status = ST_OK;
        end

        result              = '0;
        result.parse_status = status;
        result.node_addr    = (r_pos == POS_SLAVE) ? i_data_byte : r_slave;
        if (status == ST_OK) begin
            result.status_bits       = r_words[0][6:0];
            result.price_per_unit    = r_words[1];
            result.delivery_quantity = {r_words[2], r_words[3]};
            result.delivery_amount   = {r_words[4], r_words[5]};
            result.quantity_total    = r_qty_acc;
            result.amount_total      = r_amt_acc;
            result.line_pressure     = r_words[6];
            result.flow_value        = r_words[7];
            result.fault_flags       = r_words[8];
            result.ambient_temp      = r_words[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_slave     <= '0;
            r_function  <= '0;
            r_count     <= '0;
            r_bcd_fault <= 1'b0;
            r_pending   <= '0;
            for (int i = 0; i < WORD_SLOTS; i++) begin
                r_words[i] <= '0;
            end
            r_qty_acc   <= '0;
            r_amt_acc   <= '0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_slave     <= n_slave;
            r_function  <= n_function;
            r_count     <= n_count;
            r_bcd_fault <= n_bcd_fault;
            r_pending   <= n_pending;
            r_words     <= n_words;
            r_qty_acc   <= n_qty_acc;
            r_amt_acc   <= n_amt_acc;
        end
    end

    // Output register with a skid slot. The skid fills only when a result is
    // produced while the output is held by a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= produce;
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || !i_stall) begin
            if (produce) begin
                r_out <= result;
            end
        end else if (produce) begin
            r_skid <= result;
        end
    end

    assign o_stall             = r_skid_valid;
    assign o_valid             = r_out_valid;
    assign o_parse_status      = r_out.parse_status;
    assign o_node_addr         = r_out.node_addr;
    assign o_status_bits       = r_out.status_bits;
    assign o_price_per_unit    = r_out.price_per_unit;
    assign o_delivery_quantity = r_out.delivery_quantity;
    assign o_delivery_amount   = r_out.delivery_amount;
    assign o_quantity_total    = r_out.quantity_total;
    assign o_amount_total      = r_out.amount_total;
    assign o_line_pressure     = r_out.line_pressure;
    assign o_flow_value        = r_out.flow_value;
    assign o_fault_flags       = r_out.fault_flags;
    assign o_ambient_temp      = r_out.ambient_temp;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while the output slot is empty");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> (r_pos == '0 && r_crc == CRC_INIT && !r_bcd_fault))
        else $error("frame state not cleared after the last byte");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_last_byte && r_pos != POS_MAX) |=> (r_pos == $past(r_pos) + 6'd1))
        else $error("byte position did not advance on a transfer");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_status != ST_OK) |->
            (o_price_per_unit == '0 && o_quantity_total == '0 && o_ambient_temp == '0))
        else $error("failed frame reports nonzero data fields");

endmodule

### dv/modbus_telemetry_frame_parser_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_telemetry_frame_parser_checker
// Watches both channels of the telemetry frame parser. It decodes every
// transferred byte with its own copy of the frame state and queues the
// decoded result on each last byte. Each transferred result is compared,
// field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
module modbus_telemetry_frame_parser_checker
    import mtfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [2:0]         i_parse_status,
    input  logic [7:0]         i_node_addr,
    input  logic [6:0]         i_status_bits,
    input  logic [15:0]        i_price_per_unit,
    input  logic [31:0]        i_delivery_quantity,
    input  logic [31:0]        i_delivery_amount,
    input  logic [39:0]        i_quantity_total,
    input  logic [39:0]        i_amount_total,
    input  logic [15:0]        i_line_pressure,
    input  logic [15:0]        i_flow_value,
    input  logic [15:0]        i_fault_flags,
    input  logic signed [15:0] i_ambient_temp,
    output int                 o_mismatches,
    output int                 o_awaited,
    output int                 o_compared,
    output int                 o_ok_results
);

    // Data byte indexes (counted from the first data byte) of the BCD totals.
    localparam int BCD_FIRST_INDEX = 12;
    localparam int BCD_SPLIT_INDEX = 18;
    localparam int BCD_LAST_INDEX  = 23;
    localparam int UPPER_WORD_SHIFT = 6;

    logic [5:0]  byte_pos;
    logic [15:0] crc_acc;
    logic [7:0]  slave_byte;
    logic [7:0]  func_byte;
    logic [7:0]  count_byte;
    logic [7:0]  high_byte;
    logic        digit_fault;
    logic [15:0] reg_words [10];
    logic [39:0] bcd_totals [2];
    t_result     awaited_results [$];
    t_result     want;
    int          fails;
    int          compared;
    int          ok_results;

    // Bit-serial form: each data bit is folded into the low end as it shifts.
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic clear_frame();
        byte_pos    = '0;
        crc_acc     = CRC_INIT;
        slave_byte  = '0;
        func_byte   = '0;
        count_byte  = '0;
        high_byte   = '0;
        digit_fault = 1'b0;
        foreach (reg_words[i]) reg_words[i] = '0;
        foreach (bcd_totals[i]) bcd_totals[i] = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [5:0]    at;
        int            d;
        int            w;
        int            which;
        t_parse_status verdict;
        t_result       r;
        at = byte_pos;
        crc_acc = crc_step(crc_acc, b);
        if (at == POS_SLAVE) begin
            slave_byte = b;
        end else if (at == POS_FUNCTION) begin
            func_byte = b;
        end else if (at == POS_COUNT) begin
            count_byte = b;
        end else if (at >= POS_DATA_FIRST && at <= POS_DATA_LAST) begin
            d = int'(at) - int'(POS_DATA_FIRST);
            if (d >= BCD_FIRST_INDEX && d <= BCD_LAST_INDEX) begin
                which = (d >= BCD_SPLIT_INDEX) ? 1 : 0;
                if (b[7:4] > 4'd9 || b[3:0] > 4'd9) digit_fault = 1'b1;
                bcd_totals[which] = bcd_totals[which] * 40'd100
                                  + {36'd0, b[7:4]} * 40'd10 + {36'd0, b[3:0]};
            end else if (d % 2 == 0) begin
                high_byte = b;
            end else begin
                w = d / 2;
                if (w > 5) w = w - UPPER_WORD_SHIFT;
                reg_words[w] = {high_byte, b};
            end
        end
        if (byte_pos != POS_MAX) byte_pos = byte_pos + 6'd1;

        if (last) begin
            if (at < POS_MIN_LAST) verdict = ST_SHORT;
            else if (func_byte != FUNC_READ_HOLDING) verdict = ST_BAD_FUNC;
            else if (count_byte != DATA_BYTE_COUNT) verdict = ST_SHORT;
            else if (crc_acc != 16'h0000) verdict = ST_CRC_ERR;
            else if (digit_fault) verdict = ST_BAD_BCD;
            else verdict = ST_OK;

            r = '0;
            r.parse_status = verdict;
            r.node_addr    = slave_byte;
            if (verdict == ST_OK) begin
                r.status_bits       = reg_words[0][6:0];
                r.price_per_unit    = reg_words[1];
                r.delivery_quantity = {reg_words[2], reg_words[3]};
                r.delivery_amount   = {reg_words[4], reg_words[5]};
                r.quantity_total    = bcd_totals[0];
                r.amount_total      = bcd_totals[1];
                r.line_pressure     = reg_words[6];
                r.flow_value        = reg_words[7];
                r.fault_flags       = reg_words[8];
                r.ambient_temp      = reg_words[9];
            end
            awaited_results.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            awaited_results.delete();
        end else begin
            // The result side goes first: a result never leaves in the cycle
            // its last byte is transferred.
            if (i_res_valid && !i_res_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no frame outstanding, expected none, %s",
                             $time, "got a result");
                    $display("%0t: got status %0d node 0x%0h",
                             $time, i_parse_status, i_node_addr);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("parse_status", want.parse_status, i_parse_status);
                    check_field("node_addr", want.node_addr, i_node_addr);
                    check_field("status_bits", want.status_bits, i_status_bits);
                    check_field("price_per_unit", want.price_per_unit, i_price_per_unit);
                    check_field("delivery_quantity", want.delivery_quantity, i_delivery_quantity);
                    check_field("delivery_amount", want.delivery_amount, i_delivery_amount);
                    check_field("quantity_total", want.quantity_total, i_quantity_total);
                    check_field("amount_total", want.amount_total, i_amount_total);
                    check_field("line_pressure", want.line_pressure, i_line_pressure);
                    check_field("flow_value", want.flow_value, i_flow_value);
                    check_field("fault_flags", want.fault_flags, i_fault_flags);
                    check_field("ambient_temp", {48'd0, want.ambient_temp},
                                {48'd0, i_ambient_temp});
                    compared++;
                    if (want.parse_status == ST_OK) ok_results++;
                end
            end
            if (i_in_valid && !i_in_stall) absorb_byte(i_in_byte, i_in_last);
        end
        o_mismatches <= fails;
        o_awaited    <= awaited_results.size();
        o_compared   <= compared;
        o_ok_results <= ok_results;
    end

endmodule

### dv/modbus_telemetry_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_telemetry_frame_parser_tb
// Sends response frames byte by byte into the telemetry frame parser: a
// directed set covering field extremes, every status and long frames, then
// random frames, mostly well formed with random register contents. Both
// channels idle at random, and the result side holds off once for a long
// stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module modbus_telemetry_frame_parser_tb;
    import mtfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 20;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_MAX    = 2;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_parse_status;
    logic [7:0]         o_node_addr;
    logic [6:0]         o_status_bits;
    logic [15:0]        o_price_per_unit;
    logic [31:0]        o_delivery_quantity;
    logic [31:0]        o_delivery_amount;
    logic [39:0]        o_quantity_total;
    logic [39:0]        o_amount_total;
    logic [15:0]        o_line_pressure;
    logic [15:0]        o_flow_value;
    logic [15:0]        o_fault_flags;
    logic signed [15:0] o_ambient_temp;

    int mismatches;
    int awaited;
    int compared;
    int ok_results;

    logic [7:0] frame_buf [$];
    bit         no_gaps;
    bit         random_phase;
    int         bytes_sent;
    int         frames_sent;
    int         cycle_count;

    modbus_telemetry_frame_parser uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_parse_status      (o_parse_status),
        .o_node_addr         (o_node_addr),
        .o_status_bits       (o_status_bits),
        .o_price_per_unit    (o_price_per_unit),
        .o_delivery_quantity (o_delivery_quantity),
        .o_delivery_amount   (o_delivery_amount),
        .o_quantity_total    (o_quantity_total),
        .o_amount_total      (o_amount_total),
        .o_line_pressure     (o_line_pressure),
        .o_flow_value        (o_flow_value),
        .o_fault_flags       (o_fault_flags),
        .o_ambient_temp      (o_ambient_temp)
    );

    modbus_telemetry_frame_parser_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_stall          (o_stall),
        .i_in_byte           (i_data_byte),
        .i_in_last           (i_last_byte),
        .i_res_valid         (o_valid),
        .i_res_stall         (i_stall),
        .i_parse_status      (o_parse_status),
        .i_node_addr         (o_node_addr),
        .i_status_bits       (o_status_bits),
        .i_price_per_unit    (o_price_per_unit),
        .i_delivery_quantity (o_delivery_quantity),
        .i_delivery_amount   (o_delivery_amount),
        .i_quantity_total    (o_quantity_total),
        .i_amount_total      (o_amount_total),
        .i_line_pressure     (o_line_pressure),
        .i_flow_value        (o_flow_value),
        .i_fault_flags       (o_fault_flags),
        .i_ambient_temp      (o_ambient_temp),
        .o_mismatches        (mismatches),
        .o_awaited           (awaited),
        .o_compared          (compared),
        .o_ok_results        (ok_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, awaited);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] field_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] bcd_byte();
        int         r;
        logic [3:0] hi;
        logic [3:0] lo;
        r  = $urandom_range(0, 9);
        hi = 4'($urandom_range(0, 9));
        lo = 4'($urandom_range(0, 9));
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h99;
        return {hi, lo};
    endfunction

    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i]) begin
            c = c ^ {8'h00, frame_buf[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic begin_frame(input logic [7:0] slave, input logic [7:0] fcode,
                               input logic [7:0] count);
        frame_buf.delete();
        frame_buf.push_back(slave);
        frame_buf.push_back(fcode);
        frame_buf.push_back(count);
    endtask

    task automatic add_data(input int fill);
        logic [7:0] b;
        bit         is_bcd;
        for (int i = 0; i < DATA_BYTE_COUNT; i++) begin
            is_bcd = (i + POS_DATA_FIRST >= POS_BCD_FIRST)
                  && (i + POS_DATA_FIRST <= POS_BCD_LAST);
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_MAX:  b = is_bcd ? 8'h99 : 8'hFF;
                default:   b = is_bcd ? bcd_byte() : field_byte();
            endcase
            frame_buf.push_back(b);
        end
    endtask

    // Puts a nibble above nine into one digit of either totalizer.
    task automatic break_digit();
        int         k;
        logic [7:0] b;
        k = $urandom_range(POS_BCD_FIRST, POS_BCD_LAST);
        b = frame_buf[k];
        if ($urandom_range(0, 1)) begin
            b[7:4] = 4'($urandom_range(10, 15));
        end else begin
            b[3:0] = 4'($urandom_range(10, 15));
        end
        frame_buf[k] = b;
    endtask

    task automatic seal_frame();
        logic [15:0] c;
        c = frame_crc();
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic flip_byte(input int k, input logic [7:0] mask);
        logic [7:0] b;
        b = frame_buf[k];
        frame_buf[k] = b ^ mask;
    endtask

    task automatic build_good(input int fill);
        begin_frame(field_byte(), FUNC_READ_HOLDING, DATA_BYTE_COUNT);
        add_data(fill);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_sent++;
    endtask

    // Result side: random stall runs, and one long hold-off once the random
    // frames start so that both output slots fill and the input stalls.
    initial begin : result_sink
        int r;
        int run;
        bit lvl;
        bit held;
        held = 1'b0;
        i_stall <= 1'b0;
        repeat (8) @(posedge i_clk);
        forever begin
            if (random_phase && !held) begin
                held = 1'b1;
                lvl  = 1'b1;
                run  = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    lvl = 1'b0;
                    run = $urandom_range(1, 4);
                end else if (r < 80) begin
                    lvl = 1'b1;
                    run = $urandom_range(1, 3);
                end else if (r < 92) begin
                    lvl = 1'b0;
                    run = $urandom_range(20, 60);
                end else begin
                    lvl = 1'b1;
                    run = $urandom_range(8, 40);
                end
            end
            i_stall <= lvl;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : frame_source
        int kind;
        int start_bytes;
        int n;
        logic [7:0] code;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A lone byte flagged as last.
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        // Every field at its maximum, totalizers all nines.
        begin_frame(8'hFF, FUNC_READ_HOLDING, DATA_BYTE_COUNT);
        add_data(FILL_MAX);
        seal_frame();
        send_frame();
        // Every field zero.
        begin_frame(8'h00, FUNC_READ_HOLDING, DATA_BYTE_COUNT);
        add_data(FILL_ZERO);
        seal_frame();
        send_frame();
        // Wrong function code wins over a wrong byte count.
        begin_frame(8'h11, 8'h04, 8'h00);
        add_data(FILL_RANDOM);
        seal_frame();
        send_frame();
        // Wrong byte count wins over a CRC mismatch.
        begin_frame(8'h22, FUNC_READ_HOLDING, 8'd31);
        add_data(FILL_RANDOM);
        seal_frame();
        flip_byte(frame_buf.size() - 1, 8'h01);
        send_frame();
        // CRC mismatch wins over a bad digit.
        build_good(FILL_RANDOM);
        break_digit();
        seal_frame();
        flip_byte(frame_buf.size() - 2, 8'h80);
        send_frame();
        // Bad digits alone, low nibble in the first totalizer, high in the second.
        build_good(FILL_RANDOM);
        frame_buf[POS_BCD_FIRST] = 8'h9A;
        seal_frame();
        send_frame();
        build_good(FILL_RANDOM);
        frame_buf[POS_BCD_LAST] = 8'hF9;
        seal_frame();
        send_frame();
        // One byte short of the minimum length.
        build_good(FILL_RANDOM);
        seal_frame();
        void'(frame_buf.pop_back());
        send_frame();
        // Long frame past the position limit, CRC over every byte.
        build_good(FILL_RANDOM);
        repeat (31) frame_buf.push_back(8'($urandom_range(0, 255)));
        seal_frame();
        send_frame();

        random_phase <= 1'b1;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            kind    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (kind < 55) begin
                build_good(FILL_RANDOM);
                seal_frame();
            end else if (kind < 65) begin
                build_good(FILL_RANDOM);
                break_digit();
                seal_frame();
            end else if (kind < 72) begin
                build_good(FILL_RANDOM);
                seal_frame();
                flip_byte($urandom_range(POS_DATA_FIRST, frame_buf.size() - 1),
                          8'($urandom_range(1, 255)));
            end else if (kind < 77) begin
                code = 8'($urandom_range(0, 255));
                if (code == FUNC_READ_HOLDING) code = 8'h83;
                begin_frame(field_byte(), code, DATA_BYTE_COUNT);
                add_data(FILL_RANDOM);
                seal_frame();
            end else if (kind < 82) begin
                code = 8'($urandom_range(0, 255));
                if (code == DATA_BYTE_COUNT) code = 8'd33;
                begin_frame(field_byte(), FUNC_READ_HOLDING, code);
                add_data(FILL_RANDOM);
                seal_frame();
            end else if (kind < 90) begin
                build_good(FILL_RANDOM);
                seal_frame();
                n = $urandom_range(1, 36);
                while (frame_buf.size() > n) void'(frame_buf.pop_back());
            end else if (kind < 95) begin
                build_good(FILL_RANDOM);
                repeat ($urandom_range(1, 35)) frame_buf.push_back(8'($urandom_range(0, 255)));
                seal_frame();
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 70)) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d frames; %0d results compared, %0d with status ok.",
                 bytes_sent, frames_sent, compared, ok_results);
        $display("Covered every status, field extremes, frames past the position limit %s",
                 "and a long result hold-off.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
